FILE: rtl/core/cpu6502_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu6502_pkg
// Shared types, opcodes and codes of the 6502 instruction execute unit.
// ----------------------------------------------------------------------------
package cpu6502_pkg;

    localparam logic [15:0] STACK_BASE = 16'h0100;
    localparam logic [15:0] PC_RESET   = 16'h0000;
    localparam logic [7:0]  S_RESET    = 8'hfd;
    localparam logic [7:0]  P_RESET    = 8'h24;

    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_I = 2;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_N = 7;

    typedef enum logic [1:0] {
        ST_EXEC = 2'd0,
        ST_ZERO = 2'd1,
        ST_HALT = 2'd2
    } status_t;

    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_BYTE = 2'd1;
    localparam logic [1:0] WR_WORD = 2'd2;

    localparam logic [7:0] OP_BRK_ZERO = 8'h00;
    localparam logic [7:0] OP_PHP      = 8'h08;
    localparam logic [7:0] OP_ORA_IMM  = 8'h09;
    localparam logic [7:0] OP_BPL      = 8'h10;
    localparam logic [7:0] OP_CLC      = 8'h18;
    localparam logic [7:0] OP_JSR      = 8'h20;
    localparam logic [7:0] OP_BIT_ZP   = 8'h24;
    localparam logic [7:0] OP_PLP      = 8'h28;
    localparam logic [7:0] OP_AND_IMM  = 8'h29;
    localparam logic [7:0] OP_BMI      = 8'h30;
    localparam logic [7:0] OP_SEC      = 8'h38;
    localparam logic [7:0] OP_PHA      = 8'h48;
    localparam logic [7:0] OP_EOR_IMM  = 8'h49;
    localparam logic [7:0] OP_JMP_ABS  = 8'h4c;
    localparam logic [7:0] OP_BVC      = 8'h50;
    localparam logic [7:0] OP_RTS      = 8'h60;
    localparam logic [7:0] OP_PLA      = 8'h68;
    localparam logic [7:0] OP_ADC_IMM  = 8'h69;
    localparam logic [7:0] OP_BVS      = 8'h70;
    localparam logic [7:0] OP_SEI      = 8'h78;
    localparam logic [7:0] OP_STA_ZP   = 8'h85;
    localparam logic [7:0] OP_STX_ZP   = 8'h86;
    localparam logic [7:0] OP_DEY      = 8'h88;
    localparam logic [7:0] OP_TXA      = 8'h8a;
    localparam logic [7:0] OP_STX_ABS  = 8'h8e;
    localparam logic [7:0] OP_BCC      = 8'h90;
    localparam logic [7:0] OP_TYA      = 8'h98;
    localparam logic [7:0] OP_TXS      = 8'h9a;
    localparam logic [7:0] OP_LDY_IMM  = 8'ha0;
    localparam logic [7:0] OP_LDX_IMM  = 8'ha2;
    localparam logic [7:0] OP_TAY      = 8'ha8;
    localparam logic [7:0] OP_LDA_IMM  = 8'ha9;
    localparam logic [7:0] OP_TAX      = 8'haa;
    localparam logic [7:0] OP_LDA_ABS  = 8'had;
    localparam logic [7:0] OP_LDX_ABS  = 8'hae;
    localparam logic [7:0] OP_BCS      = 8'hb0;
    localparam logic [7:0] OP_CLV      = 8'hb8;
    localparam logic [7:0] OP_TSX      = 8'hba;
    localparam logic [7:0] OP_CPY_IMM  = 8'hc0;
    localparam logic [7:0] OP_INY      = 8'hc8;
    localparam logic [7:0] OP_CMP_IMM  = 8'hc9;
    localparam logic [7:0] OP_DEX      = 8'hca;
    localparam logic [7:0] OP_BNE      = 8'hd0;
    localparam logic [7:0] OP_CLD      = 8'hd8;
    localparam logic [7:0] OP_CPX_IMM  = 8'he0;
    localparam logic [7:0] OP_INX      = 8'he8;
    localparam logic [7:0] OP_SBC_IMM  = 8'he9;
    localparam logic [7:0] OP_NOP      = 8'hea;
    localparam logic [7:0] OP_BEQ      = 8'hf0;
    localparam logic [7:0] OP_SED      = 8'hf8;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  s;
        logic [7:0]  p;
    } cpu_state_t;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] operand_lo;
        logic [7:0] operand_hi;
        logic [7:0] read_lo;
        logic [7:0] read_hi;
    } instr_t;

    typedef struct packed {
        cpu_state_t  state;
        logic [1:0]  write_count;
        logic [15:0] write_address;
        logic [7:0]  write_lo;
        logic [7:0]  write_hi;
        status_t     status;
    } exec_result_t;

endpackage

FILE: rtl/core/cpu6502_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu6502_exec
// Decode and execute of one instruction against the current register state.
// ----------------------------------------------------------------------------
module cpu6502_exec (
    input  cpu6502_pkg::cpu_state_t   cur,
    input  logic                      halted,
    input  cpu6502_pkg::instr_t       instr,
    output cpu6502_pkg::exec_result_t res,
    output logic                      halt_set
);
    import cpu6502_pkg::*;

    function automatic logic [7:0] with_zn(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r       = p;
        r[FL_Z] = (v == 8'h00);
        r[FL_N] = v[7];
        return r;
    endfunction

    logic [15:0] abs_addr;
    logic [15:0] pc_br;
    logic [15:0] pc_ret;
    logic [7:0]  add_arg;
    logic [8:0]  add_sum;
    logic [7:0]  cmp_reg;
    logic [8:0]  cmp_diff;
    logic [7:0]  s_dec;

    assign abs_addr = {instr.operand_hi, instr.operand_lo};
    assign pc_ret   = cur.pc + 16'd2;
    assign pc_br    = pc_ret + {{8{instr.operand_lo[7]}}, instr.operand_lo};
    assign add_arg  = (instr.opcode == OP_SBC_IMM) ? ~instr.operand_lo : instr.operand_lo;
    assign add_sum  = {1'b0, cur.a} + {1'b0, add_arg} + {8'h00, cur.p[FL_C]};
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, instr.operand_lo};
    assign s_dec    = cur.s - 8'd1;

    always_comb begin
        unique case (instr.opcode)
            OP_CPY_IMM: cmp_reg = cur.y;
            OP_CPX_IMM: cmp_reg = cur.x;
            default:    cmp_reg = cur.a;
        endcase
    end

    always_comb begin
        cpu_state_t n;
        n                 = cur;
        halt_set          = 1'b0;
        res.write_count   = WR_NONE;
        res.write_address = 16'h0000;
        res.write_lo      = 8'h00;
        res.write_hi      = 8'h00;
        res.status        = ST_EXEC;
        if (halted) begin
            res.status = ST_HALT;
        end else begin
            unique case (instr.opcode)
                OP_BRK_ZERO: res.status = ST_ZERO;
                OP_PHP, OP_PHA: begin
                    res.write_count   = WR_BYTE;
                    res.write_address = STACK_BASE | {8'h00, cur.s};
                    res.write_lo      = (instr.opcode == OP_PHP) ? (cur.p | 8'h30) : cur.a;
                    n.s               = s_dec;
                    n.pc              = cur.pc + 16'd1;
                end
                OP_ORA_IMM, OP_AND_IMM, OP_EOR_IMM, OP_LDA_IMM: begin
                    unique case (instr.opcode)
                        OP_ORA_IMM: n.a = cur.a | instr.operand_lo;
                        OP_AND_IMM: n.a = cur.a & instr.operand_lo;
                        OP_EOR_IMM: n.a = cur.a ^ instr.operand_lo;
                        default:    n.a = instr.operand_lo;
                    endcase
                    n.p  = with_zn(cur.p, n.a);
                    n.pc = cur.pc + 16'd2;
                end
                OP_BPL: n.pc = cur.p[FL_N] ? pc_ret : pc_br;
                OP_BMI: n.pc = cur.p[FL_N] ? pc_br : pc_ret;
                OP_BVC: n.pc = cur.p[FL_V] ? pc_ret : pc_br;
                OP_BVS: n.pc = cur.p[FL_V] ? pc_br : pc_ret;
                OP_BCC: n.pc = cur.p[FL_C] ? pc_ret : pc_br;
                OP_BCS: n.pc = cur.p[FL_C] ? pc_br : pc_ret;
                OP_BNE: n.pc = cur.p[FL_Z] ? pc_ret : pc_br;
                OP_BEQ: n.pc = cur.p[FL_Z] ? pc_br : pc_ret;
                OP_CLC, OP_SEC, OP_SEI, OP_CLV, OP_CLD, OP_SED: begin
                    unique case (instr.opcode)
                        OP_CLC:  n.p[FL_C] = 1'b0;
                        OP_SEC:  n.p[FL_C] = 1'b1;
                        OP_SEI:  n.p[FL_I] = 1'b1;
                        OP_CLV:  n.p[FL_V] = 1'b0;
                        OP_CLD:  n.p[FL_D] = 1'b0;
                        default: n.p[FL_D] = 1'b1;
                    endcase
                    n.pc = cur.pc + 16'd1;
                end
                OP_JSR: begin
                    res.write_count   = WR_WORD;
                    res.write_address = STACK_BASE | {8'h00, s_dec};
                    res.write_lo      = pc_ret[7:0];
                    res.write_hi      = pc_ret[15:8];
                    n.s               = cur.s - 8'd2;
                    n.pc              = abs_addr;
                end
                OP_BIT_ZP: begin
                    n.p       = {instr.read_lo[7:6], cur.p[5:0]};
                    n.p[FL_Z] = ((cur.a & instr.read_lo) == 8'h00);
                    n.pc      = cur.pc + 16'd2;
                end
                OP_PLP: begin
                    n.s  = cur.s + 8'd1;
                    n.p  = {instr.read_lo[7:6], cur.p[5:4], instr.read_lo[3:0]};
                    n.pc = cur.pc + 16'd1;
                end
                OP_JMP_ABS: n.pc = abs_addr;
                OP_RTS: begin
                    n.s  = cur.s + 8'd2;
                    n.pc = {instr.read_hi, instr.read_lo} + 16'd1;
                end
                OP_PLA: begin
                    n.s  = cur.s + 8'd1;
                    n.a  = instr.read_lo;
                    n.p  = with_zn(cur.p, instr.read_lo);
                    n.pc = cur.pc + 16'd1;
                end
                OP_ADC_IMM, OP_SBC_IMM: begin
                    n.a       = add_sum[7:0];
                    n.p       = with_zn(cur.p, add_sum[7:0]);
                    n.p[FL_V] = (cur.a[7] ^ add_sum[7]) & (add_arg[7] ^ add_sum[7]);
                    n.p[FL_C] = add_sum[8];
                    n.pc      = cur.pc + 16'd2;
                end
                OP_STA_ZP, OP_STX_ZP: begin
                    res.write_count   = WR_BYTE;
                    res.write_address = {8'h00, instr.operand_lo};
                    res.write_lo      = (instr.opcode == OP_STA_ZP) ? cur.a : cur.x;
                    n.pc              = cur.pc + 16'd2;
                end
                OP_STX_ABS: begin
                    res.write_count   = WR_BYTE;
                    res.write_address = abs_addr;
                    res.write_lo      = cur.x;
                    n.pc              = cur.pc + 16'd3;
                end
                OP_DEY, OP_INY, OP_TAY, OP_LDY_IMM: begin
                    unique case (instr.opcode)
                        OP_DEY:  n.y = cur.y - 8'd1;
                        OP_INY:  n.y = cur.y + 8'd1;
                        OP_TAY:  n.y = cur.a;
                        default: n.y = instr.operand_lo;
                    endcase
                    n.p  = with_zn(cur.p, n.y);
                    n.pc = (instr.opcode == OP_LDY_IMM) ? pc_ret : cur.pc + 16'd1;
                end
                OP_DEX, OP_INX, OP_TAX, OP_TSX, OP_LDX_IMM: begin
                    unique case (instr.opcode)
                        OP_DEX:  n.x = cur.x - 8'd1;
                        OP_INX:  n.x = cur.x + 8'd1;
                        OP_TAX:  n.x = cur.a;
                        OP_TSX:  n.x = cur.s;
                        default: n.x = instr.operand_lo;
                    endcase
                    n.p  = with_zn(cur.p, n.x);
                    n.pc = (instr.opcode == OP_LDX_IMM) ? pc_ret : cur.pc + 16'd1;
                end
                OP_TXA, OP_TYA: begin
                    n.a  = (instr.opcode == OP_TXA) ? cur.x : cur.y;
                    n.p  = with_zn(cur.p, n.a);
                    n.pc = cur.pc + 16'd1;
                end
                OP_TXS: begin
                    n.s  = cur.x;
                    n.pc = cur.pc + 16'd1;
                end
                OP_LDA_ABS: begin
                    n.a  = instr.read_lo;
                    n.p  = with_zn(cur.p, instr.read_lo);
                    n.pc = cur.pc + 16'd3;
                end
                OP_LDX_ABS: begin
                    n.x  = instr.read_lo;
                    n.p  = with_zn(cur.p, instr.read_lo);
                    n.pc = cur.pc + 16'd3;
                end
                OP_CPY_IMM, OP_CPX_IMM, OP_CMP_IMM: begin
                    n.p[FL_C] = ~cmp_diff[8];
                    n.p[FL_Z] = (cmp_reg == instr.operand_lo);
                    n.p[FL_N] = cmp_diff[7];
                    n.pc      = cur.pc + 16'd2;
                end
                OP_NOP: n.pc = cur.pc + 16'd1;
                default: begin
                    halt_set   = 1'b1;
                    res.status = ST_HALT;
                end
            endcase
        end
        res.state = n;
    end

endmodule

FILE: rtl/core/cpu_6502_instruction_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_6502_instruction_execute_unit
// Executes one 6502 instruction request per cycle while results are taken, and reports the new state.
// ----------------------------------------------------------------------------
// The unit accepts one instruction request per clock cycle while results are
// taken and returns one result per request. The request is captured in an
// input register and is executed against the register file once the result
// register is free; its result is registered in the result register and held
// there until it is taken. The loop from the register file through the decode
// and ALU logic back to the register file sets this single-cycle rate. A
// configuration write loads cfg_wr_data into the program counter at once;
// after reset the program counter is zero. An unknown opcode halts the unit:
// until the next reset every request reports the held state with the halted
// status and no write.
module cpu_6502_instruction_execute_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_opcode,
    input  logic [7:0]  s_operand_lo,
    input  logic [7:0]  s_operand_hi,
    input  logic [7:0]  s_read_lo,
    input  logic [7:0]  s_read_hi,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_next_pc,
    output logic [7:0]  m_acc,
    output logic [7:0]  m_index_x,
    output logic [7:0]  m_index_y,
    output logic [7:0]  m_stack_ptr,
    output logic [7:0]  m_flags,
    output logic [1:0]  m_write_count,
    output logic [15:0] m_write_address,
    output logic [7:0]  m_write_lo,
    output logic [7:0]  m_write_hi,
    output logic [1:0]  m_status
);
    import cpu6502_pkg::*;

    instr_t       instr_reg;
    logic         in_valid_reg;
    cpu_state_t   state_reg;
    logic         halted_reg;
    exec_result_t out_reg;
    logic         out_valid_reg;

    exec_result_t exec_res;
    logic         halt_set;
    logic         exec_fire;

    cpu6502_exec u_exec (
        .cur      (state_reg),
        .halted   (halted_reg),
        .instr    (instr_reg),
        .res      (exec_res),
        .halt_set (halt_set)
    );

    assign exec_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || exec_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            halted_reg    <= 1'b0;
            state_reg     <= '{pc: PC_RESET, a: 8'h00, x: 8'h00, y: 8'h00,
                               s: S_RESET, p: P_RESET};
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (exec_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (exec_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                state_reg.pc <= cfg_wr_data;
            end else if (exec_fire) begin
                state_reg <= exec_res.state;
            end
            if (exec_fire && halt_set) begin
                halted_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            instr_reg <= '{opcode: s_opcode, operand_lo: s_operand_lo,
                           operand_hi: s_operand_hi, read_lo: s_read_lo,
                           read_hi: s_read_hi};
        end
        if (exec_fire) begin
            out_reg <= exec_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_next_pc       = out_reg.state.pc;
    assign m_acc           = out_reg.state.a;
    assign m_index_x       = out_reg.state.x;
    assign m_index_y       = out_reg.state.y;
    assign m_stack_ptr     = out_reg.state.s;
    assign m_flags         = out_reg.state.p;
    assign m_write_count   = out_reg.write_count;
    assign m_write_address = out_reg.write_address;
    assign m_write_lo      = out_reg.write_lo;
    assign m_write_hi      = out_reg.write_hi;
    assign m_status        = out_reg.status;

`ifndef SYNTH
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt state cleared without reset");

    a_halted_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && halted_reg) |=> (m_status == ST_HALT && m_write_count == WR_NONE))
        else $error("halted unit reported execution or a write");

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_write_count == WR_NONE) |->
            (m_write_address == 16'h0000 && m_write_lo == 8'h00 && m_write_hi == 8'h00))
        else $error("write fields not cleared for a result without a write");

    a_state_held_when_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && halted_reg && !cfg_wr_en) |=> $stable(state_reg))
        else $error("register state changed while halted");
`endif

endmodule

FILE: bench/cpu_6502_execute_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_6502_execute_checker
// Watches both channels and the configuration port of the execute unit, keeps
// its own copy of the processor registers, predicts the result of every
// accepted instruction request and compares each returned result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module cpu_6502_execute_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_opcode,
    input  logic [7:0]  s_operand_lo,
    input  logic [7:0]  s_operand_hi,
    input  logic [7:0]  s_read_lo,
    input  logic [7:0]  s_read_hi,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_next_pc,
    input  logic [7:0]  m_acc,
    input  logic [7:0]  m_index_x,
    input  logic [7:0]  m_index_y,
    input  logic [7:0]  m_stack_ptr,
    input  logic [7:0]  m_flags,
    input  logic [1:0]  m_write_count,
    input  logic [15:0] m_write_address,
    input  logic [7:0]  m_write_lo,
    input  logic [7:0]  m_write_hi,
    input  logic [1:0]  m_status,
    output int          fail_count,
    output int          pending_count
);
    import cpu6502_pkg::*;

    cpu_state_t   cpu;
    logic         halted;
    exec_result_t outcome;
    exec_result_t predicted_results[$];
    int           errors = 0;

    function automatic logic [7:0] with_zn(input logic [7:0] flags, input logic [7:0] v);
        logic [7:0] f;
        f = flags;
        f[FL_Z] = (v == 8'h00);
        f[FL_N] = v[7];
        return f;
    endfunction

    function automatic logic [15:0] branch_target(input logic take, input logic [7:0] offset);
        return cpu.pc + 16'd2 + (take ? {{8{offset[7]}}, offset} : 16'h0000);
    endfunction

    task automatic store_byte(input logic [15:0] addr, input logic [7:0] v);
        outcome.write_count   = WR_BYTE;
        outcome.write_address = addr;
        outcome.write_lo      = v;
    endtask

    task automatic push_byte(input logic [7:0] v);
        store_byte(STACK_BASE | {8'h00, cpu.s}, v);
        cpu.s = cpu.s - 8'd1;
    endtask

    task automatic add_with_carry(input logic [7:0] v);
        logic [8:0] sum;
        sum = {1'b0, cpu.a} + {1'b0, v} + {8'h00, cpu.p[FL_C]};
        cpu.p[FL_V] = (((cpu.a ^ sum[7:0]) & (v ^ sum[7:0]) & 8'h80) != 8'h00);
        cpu.p[FL_C] = sum[8];
        cpu.a = sum[7:0];
        cpu.p = with_zn(cpu.p, cpu.a);
    endtask

    task automatic compare_reg(input logic [7:0] r, input logic [7:0] v);
        logic [7:0] diff;
        diff = r - v;
        cpu.p[FL_C] = (r >= v);
        cpu.p[FL_Z] = (r == v);
        cpu.p[FL_N] = diff[7];
    endtask

    task automatic execute_instr(input instr_t ins);
        logic [15:0] abs_addr;
        logic [15:0] return_pc;
        logic [15:0] pc1;
        logic [15:0] pc2;
        logic [15:0] pc3;
        logic [15:0] pc_next;
        status_t     st;
        abs_addr = {ins.operand_hi, ins.operand_lo};
        pc1      = cpu.pc + 16'd1;
        pc2      = cpu.pc + 16'd2;
        pc3      = cpu.pc + 16'd3;
        pc_next  = cpu.pc;
        st       = ST_EXEC;
        outcome.write_count   = WR_NONE;
        outcome.write_address = 16'h0000;
        outcome.write_lo      = 8'h00;
        outcome.write_hi      = 8'h00;
        if (halted) begin
            st = ST_HALT;
        end else begin
            case (ins.opcode)
                OP_BRK_ZERO: st = ST_ZERO;
                OP_PHP: begin
                    push_byte(cpu.p | 8'h30);
                    pc_next = pc1;
                end
                OP_ORA_IMM: begin
                    cpu.a = cpu.a | ins.operand_lo;
                    cpu.p = with_zn(cpu.p, cpu.a);
                    pc_next = pc2;
                end
                OP_BPL: pc_next = branch_target(!cpu.p[FL_N], ins.operand_lo);
                OP_CLC: begin
                    cpu.p[FL_C] = 1'b0;
                    pc_next = pc1;
                end
                OP_JSR: begin
                    return_pc = pc2;
                    outcome.write_count   = WR_WORD;
                    outcome.write_address = STACK_BASE | {8'h00, cpu.s - 8'd1};
                    outcome.write_lo      = return_pc[7:0];
                    outcome.write_hi      = return_pc[15:8];
                    cpu.s = cpu.s - 8'd2;
                    pc_next = abs_addr;
                end
                OP_BIT_ZP: begin
                    cpu.p[FL_Z] = ((cpu.a & ins.read_lo) == 8'h00);
                    cpu.p = (cpu.p & 8'h3f) | (ins.read_lo & 8'hc0);
                    pc_next = pc2;
                end
                OP_PLP: begin
                    cpu.s = cpu.s + 8'd1;
                    cpu.p = (ins.read_lo & 8'hcf) | (cpu.p & 8'h30);
                    pc_next = pc1;
                end
                OP_AND_IMM: begin
                    cpu.a = cpu.a & ins.operand_lo;
                    cpu.p = with_zn(cpu.p, cpu.a);
                    pc_next = pc2;
                end
                OP_BMI: pc_next = branch_target(cpu.p[FL_N], ins.operand_lo);
                OP_SEC: begin
                    cpu.p[FL_C] = 1'b1;
                    pc_next = pc1;
                end
                OP_PHA: begin
                    push_byte(cpu.a);
                    pc_next = pc1;
                end
                OP_EOR_IMM: begin
                    cpu.a = cpu.a ^ ins.operand_lo;
                    cpu.p = with_zn(cpu.p, cpu.a);
                    pc_next = pc2;
                end
                OP_JMP_ABS: pc_next = abs_addr;
                OP_BVC: pc_next = branch_target(!cpu.p[FL_V], ins.operand_lo);
                OP_RTS: begin
                    cpu.s = cpu.s + 8'd2;
                    pc_next = {ins.read_hi, ins.read_lo} + 16'd1;
                end
                OP_PLA: begin
                    cpu.s = cpu.s + 8'd1;
                    cpu.a = ins.read_lo;
                    cpu.p = with_zn(cpu.p, cpu.a);
                    pc_next = pc1;
                end
                OP_ADC_IMM: begin
                    add_with_carry(ins.operand_lo);
                    pc_next = pc2;
                end
                OP_BVS: pc_next = branch_target(cpu.p[FL_V], ins.operand_lo);
                OP_SEI: begin
                    cpu.p[FL_I] = 1'b1;
                    pc_next = pc1;
                end
                OP_STA_ZP: begin
                    store_byte({8'h00, ins.operand_lo}, cpu.a);
                    pc_next = pc2;
                end
                OP_STX_ZP: begin
                    store_byte({8'h00, ins.operand_lo}, cpu.x);
                    pc_next = pc2;
                end
                OP_DEY: begin
                    cpu.y = cpu.y - 8'd1;
                    cpu.p = with_zn(cpu.p, cpu.y);
                    pc_next = pc1;
                end
                OP_TXA: begin
                    cpu.a = cpu.x;
                    cpu.p = with_zn(cpu.p, cpu.a);
                    pc_next = pc1;
                end
                OP_STX_ABS: begin
                    store_byte(abs_addr, cpu.x);
                    pc_next = pc3;
                end
                OP_BCC: pc_next = branch_target(!cpu.p[FL_C], ins.operand_lo);
                OP_TYA: begin
                    cpu.a = cpu.y;
                    cpu.p = with_zn(cpu.p, cpu.a);
                    pc_next = pc1;
                end
                OP_TXS: begin
                    cpu.s = cpu.x;
                    pc_next = pc1;
                end
                OP_LDY_IMM: begin
                    cpu.y = ins.operand_lo;
                    cpu.p = with_zn(cpu.p, cpu.y);
                    pc_next = pc2;
                end
                OP_LDX_IMM: begin
                    cpu.x = ins.operand_lo;
                    cpu.p = with_zn(cpu.p, cpu.x);
                    pc_next = pc2;
                end
                OP_TAY: begin
                    cpu.y = cpu.a;
                    cpu.p = with_zn(cpu.p, cpu.y);
                    pc_next = pc1;
                end
                OP_LDA_IMM: begin
                    cpu.a = ins.operand_lo;
                    cpu.p = with_zn(cpu.p, cpu.a);
                    pc_next = pc2;
                end
                OP_TAX: begin
                    cpu.x = cpu.a;
                    cpu.p = with_zn(cpu.p, cpu.x);
                    pc_next = pc1;
                end
                OP_LDA_ABS: begin
                    cpu.a = ins.read_lo;
                    cpu.p = with_zn(cpu.p, cpu.a);
                    pc_next = pc3;
                end
                OP_LDX_ABS: begin
                    cpu.x = ins.read_lo;
                    cpu.p = with_zn(cpu.p, cpu.x);
                    pc_next = pc3;
                end
                OP_BCS: pc_next = branch_target(cpu.p[FL_C], ins.operand_lo);
                OP_CLV: begin
                    cpu.p[FL_V] = 1'b0;
                    pc_next = pc1;
                end
                OP_TSX: begin
                    cpu.x = cpu.s;
                    cpu.p = with_zn(cpu.p, cpu.x);
                    pc_next = pc1;
                end
                OP_CPY_IMM: begin
                    compare_reg(cpu.y, ins.operand_lo);
                    pc_next = pc2;
                end
                OP_INY: begin
                    cpu.y = cpu.y + 8'd1;
                    cpu.p = with_zn(cpu.p, cpu.y);
                    pc_next = pc1;
                end
                OP_CMP_IMM: begin
                    compare_reg(cpu.a, ins.operand_lo);
                    pc_next = pc2;
                end
                OP_DEX: begin
                    cpu.x = cpu.x - 8'd1;
                    cpu.p = with_zn(cpu.p, cpu.x);
                    pc_next = pc1;
                end
                OP_BNE: pc_next = branch_target(!cpu.p[FL_Z], ins.operand_lo);
                OP_CLD: begin
                    cpu.p[FL_D] = 1'b0;
                    pc_next = pc1;
                end
                OP_CPX_IMM: begin
                    compare_reg(cpu.x, ins.operand_lo);
                    pc_next = pc2;
                end
                OP_INX: begin
                    cpu.x = cpu.x + 8'd1;
                    cpu.p = with_zn(cpu.p, cpu.x);
                    pc_next = pc1;
                end
                OP_SBC_IMM: begin
                    add_with_carry(~ins.operand_lo);
                    pc_next = pc2;
                end
                OP_NOP: pc_next = pc1;
                OP_BEQ: pc_next = branch_target(cpu.p[FL_Z], ins.operand_lo);
                OP_SED: begin
                    cpu.p[FL_D] = 1'b1;
                    pc_next = pc1;
                end
                default: begin
                    halted = 1'b1;
                    st = ST_HALT;
                end
            endcase
            cpu.pc = pc_next;
        end
        outcome.state  = cpu;
        outcome.status = st;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        exec_result_t oldest;
        if (!aresetn) begin
            cpu.pc = PC_RESET;
            cpu.a  = 8'h00;
            cpu.x  = 8'h00;
            cpu.y  = 8'h00;
            cpu.s  = S_RESET;
            cpu.p  = P_RESET;
            halted = 1'b0;
            predicted_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: result with no request outstanding, next_pc %h, status %0d",
                             $time, m_next_pc, m_status);
                    errors++;
                end else begin
                    oldest = predicted_results.pop_front();
                    check_field("next_pc", oldest.state.pc, m_next_pc);
                    check_field("acc", oldest.state.a, m_acc);
                    check_field("index_x", oldest.state.x, m_index_x);
                    check_field("index_y", oldest.state.y, m_index_y);
                    check_field("stack_ptr", oldest.state.s, m_stack_ptr);
                    check_field("flags", oldest.state.p, m_flags);
                    check_field("write_count", oldest.write_count, m_write_count);
                    check_field("write_address", oldest.write_address, m_write_address);
                    check_field("write_lo", oldest.write_lo, m_write_lo);
                    check_field("write_hi", oldest.write_hi, m_write_hi);
                    check_field("status", oldest.status, m_status);
                end
            end
            if (cfg_wr_en) begin
                cpu.pc = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                execute_instr({s_opcode, s_operand_lo, s_operand_hi, s_read_lo, s_read_hi});
                predicted_results.push_back(outcome);
            end
        end
        fail_count    <= errors;
        pending_count <= predicted_results.size();
    end

endmodule

FILE: bench/cpu_6502_instruction_execute_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_6502_instruction_execute_unit_tb
// Drives directed and random instruction requests into the execute unit with
// random gaps and result stalls, moves the start address between phases, and
// finishes with an unknown opcode and the halted behavior that follows it.
// ----------------------------------------------------------------------------
module cpu_6502_instruction_execute_unit_tb;
    import cpu6502_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int NUM_PHASES      = 5;
    localparam int NUM_OPS         = 50;

    localparam logic [7:0] KNOWN_OPS [NUM_OPS] = '{
        OP_BRK_ZERO, OP_PHP,     OP_ORA_IMM, OP_BPL,     OP_CLC,
        OP_JSR,      OP_BIT_ZP,  OP_PLP,     OP_AND_IMM, OP_BMI,
        OP_SEC,      OP_PHA,     OP_EOR_IMM, OP_JMP_ABS, OP_BVC,
        OP_RTS,      OP_PLA,     OP_ADC_IMM, OP_BVS,     OP_SEI,
        OP_STA_ZP,   OP_STX_ZP,  OP_DEY,     OP_TXA,     OP_STX_ABS,
        OP_BCC,      OP_TYA,     OP_TXS,     OP_LDY_IMM, OP_LDX_IMM,
        OP_TAY,      OP_LDA_IMM, OP_TAX,     OP_LDA_ABS, OP_LDX_ABS,
        OP_BCS,      OP_CLV,     OP_TSX,     OP_CPY_IMM, OP_INY,
        OP_CMP_IMM,  OP_DEX,     OP_BNE,     OP_CLD,     OP_CPX_IMM,
        OP_INX,      OP_SBC_IMM, OP_NOP,     OP_BEQ,     OP_SED
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_opcode;
    logic [7:0]  s_operand_lo;
    logic [7:0]  s_operand_hi;
    logic [7:0]  s_read_lo;
    logic [7:0]  s_read_hi;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_next_pc;
    logic [7:0]  m_acc;
    logic [7:0]  m_index_x;
    logic [7:0]  m_index_y;
    logic [7:0]  m_stack_ptr;
    logic [7:0]  m_flags;
    logic [1:0]  m_write_count;
    logic [15:0] m_write_address;
    logic [7:0]  m_write_lo;
    logic [7:0]  m_write_hi;
    logic [1:0]  m_status;
    int          fail_count;
    int          pending_count;
    int          idle_cycles = 0;
    int          ready_hold = 0;
    bit          steady = 1'b0;

    cpu_6502_instruction_execute_unit dut (.*);

    cpu_6502_execute_checker u_checker (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h80;
            3: return 8'h7f;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            m_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) begin
                ready_hold <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_instr(input logic [7:0] op, input logic [7:0] lo,
                              input logic [7:0] hi, input logic [7:0] rd_lo,
                              input logic [7:0] rd_hi);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_operand_lo <= lo;
        s_operand_hi <= hi;
        s_read_lo    <= rd_lo;
        s_read_hi    <= rd_hi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random(input logic [7:0] op);
        send_instr(op, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_start_pc(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [7:0] op;
        bit         known;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= 16'h0000;
        s_valid      <= 1'b0;
        s_opcode     <= 8'h00;
        s_operand_lo <= 8'h00;
        s_operand_hi <= 8'h00;
        s_read_lo    <= 8'h00;
        s_read_hi    <= 8'h00;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // The first phase runs from the reset program counter.
        send_instr(OP_BRK_ZERO, 8'hff, 8'hff, 8'hff, 8'hff);
        send_instr(OP_LDA_IMM, 8'h00, 8'h00, 8'h00, 8'h00);
        send_instr(OP_LDA_IMM, 8'h7f, 8'h00, 8'h00, 8'h00);
        send_instr(OP_ADC_IMM, 8'h01, 8'h00, 8'h00, 8'h00);
        send_instr(OP_BVS, 8'h80, 8'h00, 8'h00, 8'h00);
        send_instr(OP_BMI, 8'h7f, 8'h00, 8'h00, 8'h00);
        send_instr(OP_CLV, 8'h00, 8'h00, 8'h00, 8'h00);
        send_instr(OP_BVC, 8'h00, 8'h00, 8'h00, 8'h00);
        send_instr(OP_SEC, 8'h00, 8'h00, 8'h00, 8'h00);
        send_instr(OP_SBC_IMM, 8'hff, 8'h00, 8'h00, 8'h00);
        send_instr(OP_CMP_IMM, 8'h80, 8'h00, 8'h00, 8'h00);
        send_instr(OP_BIT_ZP, 8'h10, 8'h00, 8'hc0, 8'h00);
        send_instr(OP_PHP, 8'h00, 8'h00, 8'h00, 8'h00);
        send_instr(OP_PLP, 8'h00, 8'h00, 8'hff, 8'h00);
        send_instr(OP_LDX_IMM, 8'h00, 8'h00, 8'h00, 8'h00);
        send_instr(OP_TXS, 8'h00, 8'h00, 8'h00, 8'h00);
        send_instr(OP_JSR, 8'hff, 8'hff, 8'h00, 8'h00);
        send_instr(OP_PHA, 8'h00, 8'h00, 8'h00, 8'h00);
        send_instr(OP_RTS, 8'h00, 8'h00, 8'hff, 8'hff);
        send_instr(OP_STX_ABS, 8'hff, 8'hff, 8'h00, 8'h00);
        send_instr(OP_STA_ZP, 8'hff, 8'h00, 8'h00, 8'h00);
        send_instr(OP_LDX_IMM, 8'hff, 8'h00, 8'h00, 8'h00);
        send_instr(OP_TXS, 8'h00, 8'h00, 8'h00, 8'h00);
        send_instr(OP_PLA, 8'h00, 8'h00, 8'h80, 8'h00);
        send_instr(OP_JMP_ABS, 8'hff, 8'hff, 8'h00, 8'h00);
        send_instr(OP_NOP, 8'h00, 8'h00, 8'h00, 8'h00);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: write_start_pc(16'hffff);
                1: write_start_pc(16'h0000);
                3: write_start_pc(16'hfffe);
                default: write_start_pc(16'($urandom_range(0, 65535)));
            endcase
            steady = (phase == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 3 && n == ITEMS_PER_PHASE / 2) begin
                    wait_idle();
                end
                if (phase == 0 && n < NUM_OPS) begin
                    op = KNOWN_OPS[n];
                end else begin
                    op = KNOWN_OPS[$urandom_range(0, NUM_OPS - 1)];
                end
                send_random(op);
            end
        end

        // An unknown opcode halts the unit for the rest of the run.
        wait_idle();
        write_start_pc(16'($urandom_range(0, 65535)));
        steady = 1'b0;
        send_random(OP_LDA_IMM);
        known = 1'b1;
        while (known) begin
            op = 8'($urandom_range(0, 255));
            known = 1'b0;
            foreach (KNOWN_OPS[k]) begin
                if (KNOWN_OPS[k] == op) known = 1'b1;
            end
        end
        send_random(op);
        send_random(OP_BRK_ZERO);
        send_random(OP_JSR);
        for (int n = 0; n < 12; n++) begin
            send_random(8'($urandom_range(0, 255)));
        end
        wait_idle();
        write_start_pc(16'($urandom_range(0, 65535)));
        for (int n = 0; n < 6; n++) begin
            send_random(KNOWN_OPS[$urandom_range(0, NUM_OPS - 1)]);
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
